>>> rtl/elfr_pkg.sv
// ----------------------------------------------------------------------------
// elfr_pkg
// shared types and constants of the escaped length frame receiver
// ----------------------------------------------------------------------------
package elfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd511;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ABORT   = 2'd1,
    KIND_FLUSH   = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_CHAR    = 2'd0,
    REG_ESCAPE_CHAR   = 2'd1,
    REG_FLUSH_CHAR    = 2'd2,
    REG_UNESCAPE_MASK = 2'd3
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] FRAME_CHAR_RST    = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_CHAR_RST   = 8'd125;
  localparam logic [BYTE_W-1:0] FLUSH_CHAR_RST    = 8'd124;
  localparam logic [BYTE_W-1:0] UNESCAPE_MASK_RST = 8'd32;

endpackage

>>> rtl/elfr_in_if.sv
// ----------------------------------------------------------------------------
// elfr_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface elfr_in_if;
  import elfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/elfr_out_if.sv
// ----------------------------------------------------------------------------
// elfr_out_if
// deframer result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface elfr_out_if;
  import elfr_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [BYTE_W-1:0] data;
  logic              last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

>>> rtl/escaped_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_length_frame_receiver
// byte stuffed, length prefixed deframer for a serial byte stream
// ----------------------------------------------------------------------------
// usage
//   in_rx carries one received byte per transaction. out_res carries at most
//   one result per byte: a payload byte (kind payload, data, last on the
//   final byte of a frame), an abort when a frame byte hits an open frame,
//   or a flush request. bytes that only change state give no transaction.
//   the cfg_ port is an apb style slave: frame_char at 0x0, escape_char at
//   0x4, flush_char at 0x8, unescape_mask at 0xc; pready is always high and
//   registers should only be written while the block is idle.
// pipeline and throughput
//   a byte is captured in an input register and decoded there; its result
//   goes to the output register, which drives out_res.valid, once that
//   register is empty or draining. one byte per cycle is sustained while
//   out_res.ready is high; the decode is byte compares and a 9-bit counter step.
// reset
//   rst_n (synchronous, active low) closes any frame, clears the escape and
//   counters, empties both stages and loads the default special bytes.
// stall
//   when out_res.ready is low the result register holds, the input register
//   keeps its byte and in_rx.ready drops only once both stages are full.
// ----------------------------------------------------------------------------
module escaped_length_frame_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  elfr_in_if.sink                           in_rx,
  elfr_out_if.source                        out_res,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [elfr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [elfr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [elfr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import elfr_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] frame_char_r;
  logic [BYTE_W-1:0] escape_char_r;
  logic [BYTE_W-1:0] flush_char_r;
  logic [BYTE_W-1:0] unescape_mask_r;

  cfg_reg_t cfg_sel;
  logic     cfg_wr;

  // deframer state
  logic               in_frame_r,    in_frame_nxt;
  logic               esc_pending_r, esc_pending_nxt;
  logic [INDEX_W-1:0] byte_index_r,  byte_index_nxt;
  logic [BYTE_W-1:0]  frame_len_r,   frame_len_nxt;

  // input stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_advance;

  // result stage
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r,  res_kind;
  logic [BYTE_W-1:0] out_data_r,  res_data;
  logic              out_last_r,  res_last;
  logic              res_valid;

  // decode helpers
  logic [BYTE_W-1:0] eff_byte;
  logic              take_data;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_char_r    <= FRAME_CHAR_RST;
      escape_char_r   <= ESCAPE_CHAR_RST;
      flush_char_r    <= FLUSH_CHAR_RST;
      unescape_mask_r <= UNESCAPE_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_CHAR:    frame_char_r    <= cfg_pwdata[BYTE_W-1:0];
        REG_ESCAPE_CHAR:   escape_char_r   <= cfg_pwdata[BYTE_W-1:0];
        REG_FLUSH_CHAR:    flush_char_r    <= cfg_pwdata[BYTE_W-1:0];
        REG_UNESCAPE_MASK: unescape_mask_r <= cfg_pwdata[BYTE_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_sel)
      REG_FRAME_CHAR:    cfg_prdata[BYTE_W-1:0] = frame_char_r;
      REG_ESCAPE_CHAR:   cfg_prdata[BYTE_W-1:0] = escape_char_r;
      REG_FLUSH_CHAR:    cfg_prdata[BYTE_W-1:0] = flush_char_r;
      REG_UNESCAPE_MASK: cfg_prdata[BYTE_W-1:0] = unescape_mask_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: the input stage moves on whenever the result register is
  // empty or is being drained this cycle
  // --------------------------------------------------------------------------
  assign s1_advance  = !out_valid_r || out_res.ready;
  assign in_rx.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rx.ready) begin
      s1_valid_r <= in_rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rx.valid && in_rx.ready) begin
      s1_byte_r <= in_rx.rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // byte decode
  // escape wins over everything, then frame, then flush; an escaped byte is
  // unmasked and always treated as data
  // --------------------------------------------------------------------------
  always_comb begin
    in_frame_nxt    = in_frame_r;
    esc_pending_nxt = esc_pending_r;
    byte_index_nxt  = byte_index_r;
    frame_len_nxt   = frame_len_r;
    res_valid       = 1'b0;
    res_kind        = KIND_PAYLOAD;
    res_data        = '0;
    res_last        = 1'b0;
    eff_byte        = s1_byte_r;
    take_data       = 1'b0;

    priority if (esc_pending_r) begin
      esc_pending_nxt = 1'b0;
      eff_byte        = s1_byte_r ^ unescape_mask_r;
      take_data       = 1'b1;
    end else if (s1_byte_r == escape_char_r) begin
      esc_pending_nxt = 1'b1;
    end else if (s1_byte_r == frame_char_r) begin
      // a new frame on top of an open one aborts the streamed frame
      res_valid      = in_frame_r;
      res_kind       = KIND_ABORT;
      in_frame_nxt   = 1'b1;
      frame_len_nxt  = '0;
      byte_index_nxt = '0;
    end else if (s1_byte_r == flush_char_r) begin
      res_valid      = 1'b1;
      res_kind       = KIND_FLUSH;
      in_frame_nxt   = 1'b0;
      frame_len_nxt  = '0;
      byte_index_nxt = '0;
    end else begin
      take_data = 1'b1;
    end

    if (take_data && in_frame_r) begin
      if (byte_index_r == '0) begin
        // first data byte of a frame is the payload length
        frame_len_nxt = eff_byte;
      end else if (byte_index_r <= {1'b0, frame_len_r}) begin
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_data  = eff_byte;
        res_last  = (byte_index_r == {1'b0, frame_len_r});
        if (res_last) begin
          in_frame_nxt = 1'b0;
        end
      end
      // saturate so a zero length frame just idles until frame or flush
      if (byte_index_r < INDEX_MAX) begin
        byte_index_nxt = byte_index_r + INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      esc_pending_r <= 1'b0;
      byte_index_r  <= '0;
      frame_len_r   <= '0;
    end else if (s1_valid_r && s1_advance) begin
      in_frame_r    <= in_frame_nxt;
      esc_pending_r <= esc_pending_nxt;
      byte_index_r  <= byte_index_nxt;
      frame_len_r   <= frame_len_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_last_r <= res_last;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.kind  = out_kind_r;
  assign out_res.data  = out_data_r;
  assign out_res.last  = out_last_r;

endmodule
